// File: rtl/core/cross_correlation_peak_delay_core_defines.svh
// Assertion helpers for the correlation peak core.
`ifndef CROSS_CORRELATION_PEAK_DELAY_CORE_DEFINES_SVH
`define CROSS_CORRELATION_PEAK_DELAY_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define XCPD_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("xcpd: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define XCPD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("xcpd: next-cycle check failed");

`endif

// File: rtl/core/xcpd_pkg.sv
`default_nettype none

package xcpd_pkg;

  // default sizing
  localparam int DEF_MAX_LEN     = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int DELAY_W  = 6;
  localparam int PEAK_W   = 37;
  localparam int WIDE_W   = 64;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_X  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_Y  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DROP  = 2'd2;

  // one product term moving down the pipeline
  typedef struct packed {
    logic live;   // beat carries a term slot
    logic term;   // term lies inside both sequences
    logic first;  // first term of a lag
    logic last;   // last term of a lag
    logic fin;    // last term of the last lag
  } beat_t;

  // accumulator width: full-precision sum, capped at 64 bits (wraps beyond)
  function automatic int acc_width(input int sample_bits, input int max_len);
    int raw;
    raw = 2 * sample_bits + $clog2(max_len) + 1;
    return (raw > WIDE_W) ? WIDE_W : raw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cross_correlation_peak_delay_core.sv
// Load items (x or y sample) are accepted one per cycle while the block is idle;
// a compute item runs one product term per cycle through the single
// multiply-accumulate unit, and an empty sequence goes straight to the result
// with no run. The block is busy for the whole compute.
// Reset (rst_n low, synchronous) clears both counts, the drop flag and the
// output valid; the sample memories keep their contents.
`default_nettype none
`include "cross_correlation_peak_delay_core_defines.svh"

module cross_correlation_peak_delay_core import xcpd_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [STATUS_W-1:0]           out_status,
  output logic [INDEX_W-1:0]            out_peak_index,
  output logic signed [DELAY_W-1:0]     out_delay,
  output logic signed [PEAK_W-1:0]      out_peak_value
);

  localparam int AW     = $clog2(MAX_LEN);
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int KW     = $clog2(2 * MAX_LEN);
  localparam int ACC_W  = acc_width(SAMPLE_BITS, MAX_LEN);
  localparam int CALC_W = 32;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_t;

  state_t                  state_r;
  logic [CW-1:0]           x_count_r;
  logic [CW-1:0]           y_count_r;
  logic [CW-1:0]           nx_r;
  logic [CW-1:0]           ny_r;
  logic                    ovf_r;
  logic                    start_r;
  logic                    empty_r;
  logic [STATUS_W-1:0]     status_r;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [INDEX_W-1:0]      out_peak_index_r;
  logic [DELAY_W-1:0]      out_delay_r;
  logic [PEAK_W-1:0]       out_peak_value_r;

  logic                    in_acc;
  logic                    compute_acc;
  logic                    run_start;
  logic                    counts_ok;
  logic                    counts_clear;
  logic [CW-1:0]           cur_count;
  logic                    cnt_full;
  logic                    wr_x;
  logic                    wr_y;
  logic [AW-1:0]           x_addr;
  logic [AW-1:0]           y_addr;
  logic signed [SAMPLE_BITS-1:0] x_data;
  logic signed [SAMPLE_BITS-1:0] y_data;
  beat_t                   beat;
  logic                    mac_done;
  logic [KW-1:0]           best_k;
  logic signed [ACC_W-1:0] best_v;
  logic [CALC_W-1:0]       index_full;
  logic [CALC_W-1:0]       delay_full;
  logic signed [WIDE_W-1:0] peak_ext;

  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign compute_acc = in_acc && (in_func == FUNC_COMPUTE);
  assign run_start   = compute_acc && (x_count_r != '0) && (y_count_r != '0);
  assign out_valid   = out_valid_r;

  // count sanity terms
  assign counts_ok    = (x_count_r <= CW'(MAX_LEN)) && (y_count_r <= CW'(MAX_LEN));
  assign counts_clear = (x_count_r == '0) && (y_count_r == '0) && !ovf_r;

  // load path: pick the store being filled, drop when full
  always_comb begin
    if (in_func == FUNC_LOAD_X) begin
      cur_count = x_count_r;
    end else begin
      cur_count = y_count_r;
    end
    cnt_full = (cur_count == CW'(MAX_LEN));
    wr_x     = in_acc && (in_func == FUNC_LOAD_X) && !cnt_full;
    wr_y     = in_acc && (in_func == FUNC_LOAD_Y) && !cnt_full;
  end

  // result formatting
  always_comb begin
    index_full = CALC_W'(best_k);
    delay_full = CALC_W'(best_k) - CALC_W'(nx_r) + CALC_W'(1);
    peak_ext   = WIDE_W'(best_v);
  end

  xcpd_store #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_x    (wr_x),
    .wr_y    (wr_y),
    .wr_addr (cur_count[AW-1:0]),
    .wr_data (in_sample),
    .x_addr  (x_addr),
    .y_addr  (y_addr),
    .x_data  (x_data),
    .y_data  (y_data)
  );

  xcpd_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .nx     (nx_r),
    .ny     (ny_r),
    .x_addr (x_addr),
    .y_addr (y_addr),
    .beat   (beat)
  );

  xcpd_mac #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .x_data (x_data),
    .y_data (y_data),
    .done   (mac_done),
    .best_k (best_k),
    .best_v (best_v)
  );

  // control FSM, counts and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_count_r   <= '0;
      y_count_r   <= '0;
      ovf_r       <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      start_r <= run_start;
      // result taken and no new one loaded this cycle
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_func)
              FUNC_LOAD_X: begin
                if (cnt_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  x_count_r <= x_count_r + CW'(1);
                end
              end
              FUNC_LOAD_Y: begin
                if (cnt_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  y_count_r <= y_count_r + CW'(1);
                end
              end
              FUNC_COMPUTE: begin
                nx_r      <= x_count_r;
                ny_r      <= y_count_r;
                x_count_r <= '0;
                y_count_r <= '0;
                ovf_r     <= 1'b0;
                if ((x_count_r == '0) || (y_count_r == '0)) begin
                  empty_r  <= 1'b1;
                  status_r <= STAT_EMPTY;
                  state_r  <= S_EMIT;
                end else begin
                  empty_r  <= 1'b0;
                  status_r <= ovf_r ? STAT_DROP : STAT_OK;
                  state_r  <= S_RUN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          if (mac_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            if (empty_r) begin
              out_peak_index_r <= '0;
              out_delay_r      <= '0;
              out_peak_value_r <= '0;
            end else begin
              out_peak_index_r <= index_full[INDEX_W-1:0];
              out_delay_r      <= delay_full[DELAY_W-1:0];
              out_peak_value_r <= peak_ext[PEAK_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_status     = out_status_r;
  assign out_peak_index = out_peak_index_r;
  assign out_delay      = out_delay_r;
  assign out_peak_value = out_peak_value_r;

  // checks
  `XCPD_ASSERT_IMPLY(a_done_in_run, clk, rst_n, mac_done, state_r == S_RUN)
  `XCPD_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, counts_ok)
  `XCPD_ASSERT_NEXT(a_compute_clears, clk, rst_n, compute_acc, counts_clear)
  `XCPD_ASSERT_NEXT(a_start_run, clk, rst_n, run_start, start_r && (state_r == S_RUN))

endmodule

`default_nettype wire

// File: rtl/core/xcpd_store.sv
`default_nettype none

module xcpd_store import xcpd_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int AW         = $clog2(MAX_LEN)
) (
  input  logic                          clk,
  input  logic                          wr_x,
  input  logic                          wr_y,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic [AW-1:0]                 x_addr,
  input  logic [AW-1:0]                 y_addr,
  output logic signed [SAMPLE_BITS-1:0] x_data,
  output logic signed [SAMPLE_BITS-1:0] y_data
);

  logic signed [SAMPLE_BITS-1:0] x_mem [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] y_mem [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] x_data_r;
  logic signed [SAMPLE_BITS-1:0] y_data_r;

  // reference sequence: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_x) begin
      x_mem[wr_addr] <= wr_data;
    end
    x_data_r <= x_mem[x_addr];
  end

  // received sequence: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_y) begin
      y_mem[wr_addr] <= wr_data;
    end
    y_data_r <= y_mem[y_addr];
  end

  assign x_data = x_data_r;
  assign y_data = y_data_r;

endmodule

`default_nettype wire

// File: rtl/core/xcpd_seq.sv
`default_nettype none

module xcpd_seq import xcpd_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN,
  localparam int AW     = $clog2(MAX_LEN),
  localparam int CW     = $clog2(MAX_LEN + 1),
  localparam int KW     = $clog2(2 * MAX_LEN),
  localparam int SW     = KW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] nx,
  input  logic [CW-1:0] ny,
  output logic [AW-1:0] x_addr,
  output logic [AW-1:0] y_addr,
  output beat_t         beat
);

  logic          run_r;
  logic [AW-1:0] i_r;
  logic [KW-1:0] k_r;
  beat_t         beat_r;

  logic [SW-1:0] sum;
  logic [SW-1:0] base;
  logic [SW-1:0] t_full;
  logic [KW-1:0] lags_m1;
  logic          lo_ok;
  logic          hi_ok;
  logic          last_i;
  logic          last_k;

  // y index = i + k - (nx - 1), in range only when 0 <= t < ny
  always_comb begin
    sum     = SW'(i_r) + SW'(k_r);
    base    = SW'(nx) - SW'(1);
    lo_ok   = (sum >= base);
    t_full  = sum - base;
    hi_ok   = (t_full < SW'(ny));
    lags_m1 = KW'(nx) + KW'(ny) - KW'(2);
    last_i  = (CW'(i_r) == (nx - CW'(1)));
    last_k  = (k_r == lags_m1);
  end

  assign x_addr = i_r;
  assign y_addr = t_full[AW-1:0];
  assign beat   = beat_r;

  // run flag and beat tags, aligned with the registered memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      beat_r.live  <= run_r;
      beat_r.term  <= run_r && lo_ok && hi_ok;
      beat_r.first <= (i_r == '0);
      beat_r.last  <= last_i;
      beat_r.fin   <= last_i && last_k;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last_i && last_k) begin
        run_r <= 1'b0;
      end
    end
  end

  // term index i inner, lag k outer
  always_ff @(posedge clk) begin
    if (start) begin
      i_r <= '0;
      k_r <= '0;
    end else if (run_r) begin
      if (last_i) begin
        i_r <= '0;
        k_r <= k_r + KW'(1);
      end else begin
        i_r <= i_r + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/xcpd_mac.sv
`default_nettype none

module xcpd_mac import xcpd_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int KW         = $clog2(2 * MAX_LEN),
  localparam int ACC_W      = acc_width(SAMPLE_BITS, MAX_LEN)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  beat_t                         beat,
  input  logic signed [SAMPLE_BITS-1:0] x_data,
  input  logic signed [SAMPLE_BITS-1:0] y_data,
  output logic                          done,
  output logic [KW-1:0]                 best_k,
  output logic signed [ACC_W-1:0]       best_v
);

  beat_t                          beat2_r;
  logic signed [2*SAMPLE_BITS-1:0] prod_r;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        acc_base;
  logic signed [ACC_W-1:0]        total;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        best_v_r;
  logic [KW-1:0]                  best_k_r;
  logic [KW-1:0]                  k_r;
  logic                           done_r;

  // running sum of the current lag
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    if (beat2_r.first) begin
      acc_base = '0;
    end else begin
      acc_base = acc_r;
    end
    total = acc_base + prod_ext;
  end

  // control: beat tags, lag counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat2_r <= '0;
      k_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      beat2_r <= beat;
      done_r  <= beat2_r.live && beat2_r.fin;
      if (beat2_r.live && beat2_r.last) begin
        if (beat2_r.fin) begin
          k_r <= '0;
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
    end
  end

  // multiply, accumulate, keep the first strict maximum
  always_ff @(posedge clk) begin
    if (beat.term) begin
      prod_r <= x_data * y_data;
    end else begin
      prod_r <= '0;
    end
    if (beat2_r.live) begin
      acc_r <= total;
      if (beat2_r.last && ((k_r == '0) || (total > best_v_r))) begin
        best_v_r <= total;
        best_k_r <= k_r;
      end
    end
  end

  assign done   = done_r;
  assign best_k = best_k_r;
  assign best_v = best_v_r;

endmodule

`default_nettype wire
